// ----- src/hlc_pkg.sv -----
// Shared types, constants and keyword tables for the HTTP header line classifier.
// Used by hlc_front, hlc_queue, hlc_back and the top level; depends on nothing.
`default_nettype none

package hlc_pkg;

  // Offset counters wrap at this width; reported offsets are their low 16 bits.
  localparam int OffsetBits = 16;
  localparam int FieldW     = 16;

  typedef logic [OffsetBits-1:0] offset_t;
  typedef logic [FieldW-1:0]     field_t;

  // Method keyword table.
  localparam int NumKw    = 13;
  localparam int KwMaxLen = 12;
  localparam int KwIdxW   = $clog2(NumKw);
  localparam int KwPosW   = $clog2(KwMaxLen);

  typedef logic [8*KwMaxLen-1:0] kw_text_t;

  // Each keyword sits right-justified in its slot; the first character is the
  // most significant byte of the used part.
  localparam kw_text_t KwText [NumKw] = '{
    kw_text_t'("GET "),     kw_text_t'("PUT "),      kw_text_t'("HEAD "),
    kw_text_t'("POST "),    kw_text_t'("HTTP/"),     kw_text_t'("TRACE "),
    kw_text_t'("DELETE "),  kw_text_t'("NOTIFY "),   kw_text_t'("SEARCH "),
    kw_text_t'("OPTIONS "), kw_text_t'("CONNECT "),  kw_text_t'("SUBSCRIBE "),
    kw_text_t'("UNSUBSCRIBE ")
  };

  localparam logic [KwPosW:0] KwLen [NumKw] = '{
    5'd4, 5'd4, 5'd5, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7, 5'd7, 5'd8, 5'd8, 5'd10, 5'd12
  };

  // Line class codes.
  localparam logic [2:0] ClsRequest  = 3'd0;
  localparam logic [2:0] ClsResponse = 3'd1;
  localparam logic [2:0] ClsNotify   = 3'd2;
  localparam logic [2:0] ClsBlank    = 3'd3;
  localparam logic [2:0] ClsMime     = 3'd4;
  localparam logic [2:0] ClsNotHttp  = 3'd5;

  localparam logic [2:0] KwClass [NumKw] = '{
    ClsRequest, ClsRequest, ClsRequest, ClsRequest, ClsResponse, ClsRequest,
    ClsRequest, ClsNotify, ClsNotify, ClsRequest, ClsRequest, ClsNotify, ClsNotify
  };

  // Message type codes.
  localparam logic [1:0] MsgOther = 2'd0;

  // Result kind codes.
  localparam logic KindLine    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Prefix tracker states.
  localparam logic [1:0] PfxStart = 2'd0;
  localparam logic [1:0] PfxSawM  = 2'd1;
  localparam logic [1:0] PfxMDash = 2'd2;
  localparam logic [1:0] PfxNone  = 2'd3;

  // MIME header tracker states.
  localparam logic [1:0] MimeUndecided = 2'd0;
  localparam logic [1:0] MimeHeader    = 2'd1;
  localparam logic [1:0] MimeRejected  = 2'd2;

  // Character codes.
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;

  // Event queue between the parser and the result formatter.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // One parser event: a finished line, a packet summary, or both.
  typedef struct packed {
    logic       has_line;
    logic [2:0] line_class;
    field_t     line_start;
    field_t     line_length;
    logic       has_sum;
    logic [1:0] message_type;
    field_t     body_offset;
  } event_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic       result_kind;
    logic [2:0] line_class;
    field_t     line_start;
    field_t     line_length;
    logic [1:0] message_type;
    field_t     body_offset;
    logic       last;
  } out_word_t;

  // Character at position idx of keyword k (idx below the keyword length).
  function automatic logic [7:0] kw_byte(input logic [KwIdxW-1:0] k,
                                         input logic [KwPosW-1:0] idx);
    logic [6:0] base;
    base = 7'((7'(KwLen[k]) - 7'(idx) - 7'd1) << 3);
    return KwText[k][base +: 8];
  endfunction

  // Tspecial characters that may not appear in a header name.
  function automatic logic is_tspecial(input logic [7:0] b);
    logic hit;
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- src/hlc_front.sv -----
// Byte parser: splits the byte stream into lines, tracks keyword and header
// state, and emits line and summary events. Depends on hlc_pkg.
`default_nettype none

module hlc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            packet_end_i,
  output hlc_pkg::event_t      event_o,
  output logic                 push_o
);

  hlc_pkg::offset_t byte_offset_q, byte_offset_d;
  hlc_pkg::offset_t line_begin_q, line_begin_d;
  hlc_pkg::offset_t line_pos_q, line_pos_d;
  logic [hlc_pkg::NumKw-1:0] kw_alive_q, kw_alive_d;
  logic [1:0] prefix_q, prefix_d;
  logic [1:0] mime_q, mime_d;
  logic       cr_pending_q, cr_pending_d;
  logic [1:0] sticky_q, sticky_d;
  logic       in_body_q, in_body_d;
  hlc_pkg::offset_t body_start_q, body_start_d;

  hlc_pkg::offset_t off_inc;
  logic             is_term;

  // Values after taking the current byte into the line.
  hlc_pkg::offset_t          pos_f, rel;
  logic [hlc_pkg::NumKw-1:0] alive_f;
  logic [1:0]                prefix_f, mime_f;
  logic                      do_cmp;

  // Line as seen by the classifier.
  hlc_pkg::offset_t          fin_pos, rel_len;
  logic [hlc_pkg::NumKw-1:0] fin_alive;
  logic [1:0]                fin_prefix, fin_mime;
  logic                      have_kw, can_kw;
  logic [2:0]                cls;
  logic                      do_finish;

  hlc_pkg::event_t ev;

  assign off_inc = byte_offset_q + hlc_pkg::offset_t'(1);
  assign is_term = (data_byte_i == hlc_pkg::ChCr) || (data_byte_i == hlc_pkg::ChLf);

  // Feed the byte into the prefix, keyword and header trackers.
  always_comb begin
    pos_f    = (line_pos_q != '1) ? line_pos_q + hlc_pkg::offset_t'(1) : line_pos_q;
    alive_f  = kw_alive_q;
    prefix_f = prefix_q;
    mime_f   = mime_q;
    do_cmp   = 1'b0;
    rel      = line_pos_q;

    unique case (prefix_q)
      hlc_pkg::PfxStart: begin
        if (data_byte_i == hlc_pkg::ChM) begin
          prefix_f = hlc_pkg::PfxSawM;
        end else begin
          prefix_f = hlc_pkg::PfxNone;
          do_cmp   = 1'b1;
          rel      = '0;
        end
      end
      hlc_pkg::PfxSawM: begin
        if (data_byte_i == hlc_pkg::ChDash) begin
          prefix_f = hlc_pkg::PfxMDash;
        end else begin
          prefix_f = hlc_pkg::PfxNone;
          alive_f  = '0;
        end
      end
      hlc_pkg::PfxMDash: begin
        do_cmp = 1'b1;
        rel    = line_pos_q - hlc_pkg::offset_t'(2);
      end
      default: begin
        do_cmp = 1'b1;
        rel    = line_pos_q;
      end
    endcase

    for (int k = 0; k < hlc_pkg::NumKw; k++) begin
      if (do_cmp && (rel < hlc_pkg::offset_t'(hlc_pkg::KwLen[k])) &&
          (hlc_pkg::kw_byte(hlc_pkg::KwIdxW'(k), rel[hlc_pkg::KwPosW-1:0]) != data_byte_i)) begin
        alive_f[k] = 1'b0;
      end
    end

    if (mime_q == hlc_pkg::MimeUndecided) begin
      if ((data_byte_i < 8'h20) || (data_byte_i > 8'h7E) ||
          hlc_pkg::is_tspecial(data_byte_i)) begin
        mime_f = hlc_pkg::MimeRejected;
      end else if (data_byte_i == hlc_pkg::ChColon) begin
        mime_f = hlc_pkg::MimeHeader;
      end
    end
  end

  // Classify the line: at a terminator the stored line, at packet end the fed one.
  always_comb begin
    fin_pos    = is_term ? line_pos_q : pos_f;
    fin_alive  = is_term ? kw_alive_q : alive_f;
    fin_prefix = is_term ? prefix_q : prefix_f;
    fin_mime   = is_term ? mime_q : mime_f;

    can_kw  = (fin_prefix == hlc_pkg::PfxMDash) || (fin_prefix == hlc_pkg::PfxNone);
    rel_len = (fin_prefix == hlc_pkg::PfxMDash) ? fin_pos - hlc_pkg::offset_t'(2) : fin_pos;
    have_kw = 1'b0;
    cls     = hlc_pkg::ClsNotHttp;

    // Walk from the back so the lowest matching keyword wins.
    for (int k = hlc_pkg::NumKw - 1; k >= 0; k--) begin
      if (can_kw && fin_alive[k] && (rel_len >= hlc_pkg::offset_t'(hlc_pkg::KwLen[k]))) begin
        have_kw = 1'b1;
        cls     = hlc_pkg::KwClass[k];
      end
    end
    if (!have_kw) begin
      if (fin_pos == '0) begin
        cls = hlc_pkg::ClsBlank;
      end else if (fin_mime == hlc_pkg::MimeHeader) begin
        cls = hlc_pkg::ClsMime;
      end else begin
        cls = hlc_pkg::ClsNotHttp;
      end
    end
  end

  // Next state and event for the byte on the input.
  always_comb begin
    byte_offset_d = off_inc;
    line_begin_d  = line_begin_q;
    line_pos_d    = line_pos_q;
    kw_alive_d    = kw_alive_q;
    prefix_d      = prefix_q;
    mime_d        = mime_q;
    cr_pending_d  = cr_pending_q;
    sticky_d      = sticky_q;
    in_body_d     = in_body_q;
    body_start_d  = body_start_q;
    do_finish     = 1'b0;

    if (!in_body_q) begin
      if (cr_pending_q && (data_byte_i == hlc_pkg::ChLf)) begin
        cr_pending_d = 1'b0;
        line_begin_d = off_inc;
      end else if (is_term) begin
        do_finish    = 1'b1;
        line_pos_d   = '0;
        kw_alive_d   = '1;
        prefix_d     = hlc_pkg::PfxStart;
        mime_d       = hlc_pkg::MimeUndecided;
        line_begin_d = off_inc;
        cr_pending_d = (data_byte_i == hlc_pkg::ChCr);
      end else begin
        cr_pending_d = 1'b0;
        line_pos_d   = pos_f;
        kw_alive_d   = alive_f;
        prefix_d     = prefix_f;
        mime_d       = mime_f;
        do_finish    = packet_end_i;
      end
    end

    if (do_finish) begin
      if (have_kw) begin
        if (sticky_q == hlc_pkg::MsgOther) begin
          sticky_d = 2'(cls + 3'd1);
        end
      end else if (cls == hlc_pkg::ClsNotHttp) begin
        in_body_d    = 1'b1;
        body_start_d = line_begin_q;
      end
    end

    ev              = '0;
    ev.has_line     = do_finish;
    ev.line_class   = cls;
    ev.line_start   = hlc_pkg::field_t'(line_begin_q);
    ev.line_length  = (fin_pos > hlc_pkg::offset_t'(16'hFFFF)) ? 16'hFFFF
                                                               : hlc_pkg::field_t'(fin_pos);
    ev.has_sum      = packet_end_i;
    ev.message_type = sticky_d;
    ev.body_offset  = hlc_pkg::field_t'(in_body_d ? body_start_d : off_inc);
  end

  assign event_o = ev;
  assign push_o  = accept_i && (ev.has_line || ev.has_sum);

  // Parser state; everything returns to reset after a packet's last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      line_begin_q  <= '0;
      line_pos_q    <= '0;
      kw_alive_q    <= '1;
      prefix_q      <= hlc_pkg::PfxStart;
      mime_q        <= hlc_pkg::MimeUndecided;
      cr_pending_q  <= 1'b0;
      sticky_q      <= hlc_pkg::MsgOther;
      in_body_q     <= 1'b0;
      body_start_q  <= '0;
    end else if (accept_i) begin
      if (packet_end_i) begin
        byte_offset_q <= '0;
        line_begin_q  <= '0;
        line_pos_q    <= '0;
        kw_alive_q    <= '1;
        prefix_q      <= hlc_pkg::PfxStart;
        mime_q        <= hlc_pkg::MimeUndecided;
        cr_pending_q  <= 1'b0;
        sticky_q      <= hlc_pkg::MsgOther;
        in_body_q     <= 1'b0;
        body_start_q  <= '0;
      end else begin
        byte_offset_q <= byte_offset_d;
        line_begin_q  <= line_begin_d;
        line_pos_q    <= line_pos_d;
        kw_alive_q    <= kw_alive_d;
        prefix_q      <= prefix_d;
        mime_q        <= mime_d;
        cr_pending_q  <= cr_pending_d;
        sticky_q      <= sticky_d;
        in_body_q     <= in_body_d;
        body_start_q  <= body_start_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/hlc_queue.sv -----
// Short event queue between the parser and the result formatter.
// Depends on hlc_pkg for the event type and depth.
`default_nettype none

module hlc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire hlc_pkg::event_t push_data_i,
  input  wire logic            pop_i,
  output hlc_pkg::event_t      head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  hlc_pkg::event_t entries_q [hlc_pkg::QueueDepth];
  logic [hlc_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [hlc_pkg::QueueCntW-1:0] count_q;
  logic do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == hlc_pkg::QueueCntW'(hlc_pkg::QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + hlc_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + hlc_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + hlc_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - hlc_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/hlc_back.sv -----
// Result formatter: turns queued events into one or two result words and
// holds them in the output register. Depends on hlc_pkg.
`default_nettype none

module hlc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hlc_pkg::event_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output hlc_pkg::out_word_t   out_word_o
);

  hlc_pkg::out_word_t out_q, out_d, pend_q, pend_d;
  hlc_pkg::out_word_t line_w, sum_w;
  logic out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic out_free;

  // Build both possible words from the head event.
  always_comb begin
    line_w              = '0;
    line_w.result_kind  = hlc_pkg::KindLine;
    line_w.line_class   = head_i.line_class;
    line_w.line_start   = head_i.line_start;
    line_w.line_length  = head_i.line_length;

    sum_w               = '0;
    sum_w.result_kind   = hlc_pkg::KindSummary;
    sum_w.message_type  = head_i.message_type;
    sum_w.body_offset   = head_i.body_offset;
    sum_w.last          = 1'b1;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = out_free && !pend_valid_q && !empty_i;

  // Load the output register from the waiting summary first, then the queue.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        if (head_i.has_line) begin
          out_d        = line_w;
          pend_d       = sum_w;
          pend_valid_d = head_i.has_sum;
        end else begin
          out_d = sum_w;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- src/http_header_line_classifier_top.sv -----
// Top level of the HTTP header line classifier: parser, event queue and
// result formatter. Depends on hlc_pkg, hlc_front, hlc_queue and hlc_back.
//
//   Channel   Handshake               Word
//   input     in_valid_i/in_stall_o   data_byte_i, packet_end_i
//   output    out_valid_o/out_stall_i result_kind_o .. last_o
//
// One byte is taken every cycle unless the input stalls; its results pass
// through the event queue into the output register, one result word a cycle
// unless the output stalls. A byte ending a line and the packet gives two words.
// A four-entry event queue sits between parser and formatter; the input
// stalls only while that queue is full. Reset clears all parser state.
`default_nettype none

module http_header_line_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [2:0]       line_class_o,
  output logic [15:0]      line_start_o,
  output logic [15:0]      line_length_o,
  output logic [1:0]       message_type_o,
  output logic [15:0]      body_offset_o,
  output logic             last_o
);

  hlc_pkg::event_t    push_event, head_event;
  hlc_pkg::out_word_t out_word;
  logic push, pop, q_empty, q_full, accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  hlc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .event_o      (push_event),
    .push_o       (push)
  );

  hlc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_event),
    .pop_i       (pop),
    .head_o      (head_event),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  hlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_event),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word)
  );

  assign result_kind_o  = out_word.result_kind;
  assign line_class_o   = out_word.line_class;
  assign line_start_o   = out_word.line_start;
  assign line_length_o  = out_word.line_length;
  assign message_type_o = out_word.message_type;
  assign body_offset_o  = out_word.body_offset;
  assign last_o         = out_word.last;

endmodule

`default_nettype wire
